// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers for the RTL. Define ASSERT_OFF to drop
// them all.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// implication or plain property, checked on every rising edge out of reset
`define ASSERT_CLK(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be true
`define ASSERT_NEVER(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(name, clk, rst_n, prop, msg)
`define ASSERT_NEVER(name, clk, rst_n, cond, msg)

`endif

`endif

// ===== src/icen_pkg.sv =====
// ----------------------------------------------------------------------------
// Intensity centroid package
// Widths, register codes, shared types and the back-end state encoding.
// ----------------------------------------------------------------------------
package icen_pkg;

    localparam int SAMPLE_W      = 32;
    localparam int PIX_W         = 8;
    localparam int CFG_W         = 11;
    localparam int CFG_IDX_W     = 2;
    localparam int SUM_W         = 53;
    localparam int WSUM_W        = 63;
    localparam int FRAC_W        = 8;
    localparam int MASS_W        = 60;
    localparam int COORD_W       = 19;
    localparam int MASS_SCALE    = 255;
    localparam int CFG_SIZE_RST  = 1024;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    // divider: magnitude of a weighted sum shifted up by the fraction bits
    localparam int DIV_NUM_W = WSUM_W + FRAC_W;
    localparam int DIV_DEN_W = SUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

    // frame queue, depth must be a power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_MODE  = CFG_IDX_W'(2);

    localparam logic MODE_U8  = 1'b0;
    localparam logic MODE_S32 = 1'b1;

    localparam logic signed [COORD_W-1:0] COORD_EMPTY = COORD_W'(-(1 << FRAC_W));

    typedef struct packed {
        logic [CFG_W-1:0] frame_width;
        logic [CFG_W-1:0] frame_height;
        logic             sample_mode;
    } t_cfg;

    typedef struct packed {
        logic                     mode;
        logic signed [SUM_W-1:0]  sum;
        logic signed [WSUM_W-1:0] wx;
        logic signed [WSUM_W-1:0] wy;
    } t_frame_sums;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [DIV_NUM_W-1:0] quo;
    } t_div_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MASS,
        S_CX,
        S_CY,
        S_OUT
    } t_back_state;

endpackage

// ===== src/image_intensity_centroid.sv =====
// ----------------------------------------------------------------------------
// Image intensity centroid
// Frame mass and intensity-weighted centroid of a raster pixel stream.
// ----------------------------------------------------------------------------
// Pixels enter one a beat, every cycle unless the input stalls, in raster
// order; the frame size and sample mode come from the configuration registers
// and must not change while a frame is in flight. At the last pixel of a frame
// the sums move into a two-entry queue and a back end works out the result:
// the mass by a shift-and-add reduction, then column and row centroid as two
// 71-bit divisions on one restoring divider (one quotient bit per cycle).
// Frames with at least as many pixels as the back end takes cycles per result,
// while the output is accepted, stream without a stall; smaller frames are
// held off by the input stall once the queue fills. Mass and centroid are
// signed fixed point with 8 fraction bits; an empty or negative frame gives
// found = 0 and both coordinates at -1.0.
`include "assert_macros.svh"

module image_intensity_centroid
    import icen_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_W-1:0]           i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [MASS_W-1:0]   o_mass,
    output logic signed [COORD_W-1:0]  o_centroid_x,
    output logic signed [COORD_W-1:0]  o_centroid_y,
    output logic                       o_found
);

    t_cfg          r_cfg;
    logic          w_push, w_pop;
    t_frame_sums   w_push_data, w_q_head;
    t_queue_status w_q_status;
    t_div_req      w_div_req;
    t_div_rsp      w_div_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width  <= CFG_W'(CFG_SIZE_RST);
            r_cfg.frame_height <= CFG_W'(CFG_SIZE_RST);
            r_cfg.sample_mode  <= MODE_U8;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_cfg.frame_width  <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_cfg.frame_height <= i_cfg_data;
                CFG_SAMPLE_MODE:  r_cfg.sample_mode  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    icen_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (i_valid),
        .i_sample    (i_sample),
        .o_stall     (o_stall),
        .i_q_full    (w_q_status.full),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    icen_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_head      (w_q_head),
        .o_status    (w_q_status)
    );

    icen_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    icen_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_status   (w_q_status),
        .i_q_head     (w_q_head),
        .o_pop        (w_pop),
        .o_div_req    (w_div_req),
        .i_div_rsp    (w_div_rsp),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_mass       (o_mass),
        .o_centroid_x (o_centroid_x),
        .o_centroid_y (o_centroid_y),
        .o_found      (o_found)
    );

    `ASSERT_NEVER(a_push_full, i_clk, i_rst_n, w_push && w_q_status.full, "frame pushed into full queue")
    `ASSERT_NEVER(a_pop_empty, i_clk, i_rst_n, w_pop && w_q_status.empty, "pop from empty queue")
    `ASSERT_NEVER(a_div_restart, i_clk, i_rst_n, w_div_req.start && w_div_rsp.busy, "divider restarted while busy")
    `ASSERT_CLK(a_div_runs, i_clk, i_rst_n, w_div_req.start |=> w_div_rsp.busy, "divider did not start")

endmodule

// ===== src/icen_front.sv =====
// ----------------------------------------------------------------------------
// Intensity centroid front end
// Takes one pixel a beat in raster order while the queue is not full, tracks
// column and row, keeps the pixel sum and the column- and row-weighted sums,
// and pushes them into the frame queue at the last pixel of a frame.
// ----------------------------------------------------------------------------
module icen_front
    import icen_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cfg                       i_cfg,
    input  logic                       i_valid,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    output logic                       o_stall,
    input  logic                       i_q_full,
    output logic                       o_push,
    output t_frame_sums                o_push_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam logic [CFG_W-1:0] MAX_W_C = CFG_W'(MAX_WIDTH);
    localparam logic [CFG_W-1:0] MAX_H_C = CFG_W'(MAX_HEIGHT);

    logic [COL_W-1:0]             r_col;
    logic [ROW_W-1:0]             r_row;
    logic signed [SUM_W-1:0]      r_sum, n_sum;
    logic signed [WSUM_W-1:0]     r_wx, n_wx;
    logic signed [WSUM_W-1:0]     r_wy, n_wy;

    logic signed [SAMPLE_W-1:0]   w_val;
    logic signed [SAMPLE_W+COL_W:0] w_px_col;
    logic signed [SAMPLE_W+ROW_W:0] w_px_row;
    logic [CFG_W-1:0]             w_width, w_height;
    logic                         w_col_last, w_row_last, w_accept;

    // size register: zero acts as one, anything above the maximum as the maximum
    function automatic logic [CFG_W-1:0] eff_size(input logic [CFG_W-1:0] v,
                                                  input logic [CFG_W-1:0] maxv);
        logic [CFG_W-1:0] res;
        priority if (v == '0) begin
            res = CFG_W'(1);
        end else if (v > maxv) begin
            res = maxv;
        end else begin
            res = v;
        end
        return res;
    endfunction

    assign w_width  = eff_size(i_cfg.frame_width, MAX_W_C);
    assign w_height = eff_size(i_cfg.frame_height, MAX_H_C);

    always_comb begin
        if (i_cfg.sample_mode == MODE_U8) begin
            w_val = $signed({{(SAMPLE_W-PIX_W){1'b0}}, i_sample[PIX_W-1:0]});
        end else begin
            w_val = i_sample;
        end
    end

    assign w_px_col = w_val * $signed({1'b0, r_col});
    assign w_px_row = w_val * $signed({1'b0, r_row});

    assign n_sum = r_sum + SUM_W'(w_val);
    assign n_wx  = r_wx + WSUM_W'(w_px_col);
    assign n_wy  = r_wy + WSUM_W'(w_px_row);

    assign w_col_last = (CFG_W'(r_col) + CFG_W'(1)) >= w_width;
    assign w_row_last = (CFG_W'(r_row) + CFG_W'(1)) >= w_height;

    assign o_stall  = i_q_full;
    assign w_accept = i_valid && !i_q_full;
    assign o_push   = w_accept && w_col_last && w_row_last;

    assign o_push_data.mode = i_cfg.sample_mode;
    assign o_push_data.sum  = n_sum;
    assign o_push_data.wx   = n_wx;
    assign o_push_data.wy   = n_wy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_sum <= '0;
            r_wx  <= '0;
            r_wy  <= '0;
        end else if (w_accept) begin
            if (w_col_last && w_row_last) begin
                r_col <= '0;
                r_row <= '0;
                r_sum <= '0;
                r_wx  <= '0;
                r_wy  <= '0;
            end else begin
                r_sum <= n_sum;
                r_wx  <= n_wx;
                r_wy  <= n_wy;
                if (w_col_last) begin
                    r_col <= '0;
                    r_row <= r_row + ROW_W'(1);
                end else begin
                    r_col <= r_col + COL_W'(1);
                end
            end
        end
    end

endmodule

// ===== src/icen_queue.sv =====
// ----------------------------------------------------------------------------
// Intensity centroid frame queue
// Short queue of finished frame sums between the front and back ends.
// ----------------------------------------------------------------------------
module icen_queue
    import icen_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_frame_sums   i_push_data,
    input  logic          i_pop,
    output t_frame_sums   o_head,
    output t_queue_status o_status
);

    t_frame_sums         r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;
    logic                w_wr, w_rd;

    assign o_status.full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_head         = r_mem[r_rd_ptr];

    assign w_wr = i_push && !o_status.full;
    assign w_rd = i_pop && !o_status.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + (QUEUE_AW+1)'(1);
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - (QUEUE_AW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// ===== src/icen_div.sv =====
// ----------------------------------------------------------------------------
// Intensity centroid divider
// Unsigned restoring divider, one quotient bit per cycle. Quotient is valid
// with the done pulse and holds until the next start.
// ----------------------------------------------------------------------------
module icen_div
    import icen_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy, r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_DEN_W-1:0] r_rem, n_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_NUM_W-1:0] r_nq;     // numerator bits shift out the top, quotient in the bottom
    logic [DIV_DEN_W:0]   w_trial;
    logic                 w_ge;

    assign w_trial = {r_rem, r_nq[DIV_NUM_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign n_rem   = w_ge ? DIV_DEN_W'(w_trial - {1'b0, r_den}) : w_trial[DIV_DEN_W-1:0];

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_nq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_NUM_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - DIV_CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_den <= i_req.den;
            r_nq  <= i_req.num;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_nq  <= {r_nq[DIV_NUM_W-2:0], w_ge};
        end
    end

endmodule

// ===== src/icen_back.sv =====
// ----------------------------------------------------------------------------
// Intensity centroid back end
// Pops frame sums from the queue, works out the mass by a shift-and-add
// reduction and the centroid on the divider, saturates, and holds the result
// in the output register.
// ----------------------------------------------------------------------------
module icen_back
    import icen_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_queue_status              i_q_status,
    input  t_frame_sums                i_q_head,
    output logic                       o_pop,
    output t_div_req                   o_div_req,
    input  t_div_rsp                   i_div_rsp,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [MASS_W-1:0]   o_mass,
    output logic signed [COORD_W-1:0]  o_centroid_x,
    output logic signed [COORD_W-1:0]  o_centroid_y,
    output logic                       o_found
);

    localparam int MASS_FULL_W = SUM_W + FRAC_W;
    localparam int SCALE_SH    = $clog2(MASS_SCALE + 1);

    t_back_state r_state, n_state;

    logic                      r_mode;
    logic signed [SUM_W-1:0]   r_sum;
    logic signed [WSUM_W-1:0]  r_wx, r_wy;
    logic signed [MASS_W-1:0]  r_mass;
    logic signed [COORD_W-1:0] r_cx, r_cy;
    logic                      r_found;

    logic                      r_out_valid;
    logic signed [MASS_W-1:0]  r_out_mass;
    logic signed [COORD_W-1:0] r_out_cx, r_out_cy;
    logic                      r_out_found;

    logic [SUM_W-1:0]          r_red, n_red;
    logic [SUM_W-1:0]          r_red_q, n_red_q;
    logic [SUM_W-1:0]          w_red_hi, w_sum_mag, w_quo255;
    logic                      w_red_done, w_red_step;

    logic                      w_found, w_set_mass, w_set_cx, w_set_cy, w_set_empty;
    logic                      w_load_out;
    logic signed [MASS_FULL_W-1:0] w_mass_full;
    logic [MASS_FULL_W-1:0]    w_mass_u8;
    logic signed [MASS_W-1:0]  w_mass;

    function automatic logic [SUM_W-1:0] sum_mag(input logic signed [SUM_W-1:0] s);
        logic [SUM_W-1:0] m;
        m = s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
        return m;
    endfunction

    function automatic logic [DIV_NUM_W-1:0] wsum_num(input logic signed [WSUM_W-1:0] s);
        logic [WSUM_W-1:0] m;
        m = s[WSUM_W-1] ? WSUM_W'(-s) : WSUM_W'(s);
        return DIV_NUM_W'({m, {FRAC_W{1'b0}}});
    endfunction

    // quotient magnitude to signed coordinate, saturated per sign
    function automatic logic signed [COORD_W-1:0] coord_of(input logic [DIV_NUM_W-1:0] q,
                                                           input logic neg);
        logic [COORD_W:0] v;
        logic [COORD_W-1:0] res;
        if (neg) begin
            if (q > DIV_NUM_W'(1 << (COORD_W-1))) begin
                v = (COORD_W+1)'(1 << (COORD_W-1));
            end else begin
                v = q[COORD_W:0];
            end
            res = COORD_W'(-v);
        end else begin
            if (q > DIV_NUM_W'((1 << (COORD_W-1)) - 1)) begin
                res = COORD_W'((1 << (COORD_W-1)) - 1);
            end else begin
                res = q[COORD_W-1:0];
            end
        end
        return $signed(res);
    endfunction

    assign w_found = !r_sum[SUM_W-1] && (r_sum != '0);

    // |sum|/255: 256*hi + lo = 255*hi + (hi + lo), so peel hi into the
    // quotient and fold the rest until it fits in one byte
    assign w_red_hi   = r_red >> SCALE_SH;
    assign w_red_done = (w_red_hi == '0);
    assign n_red      = w_red_hi + SUM_W'(r_red[SCALE_SH-1:0]);
    assign n_red_q    = r_red_q + w_red_hi;
    assign w_quo255   = r_red_q + {{(SUM_W-1){1'b0}}, (r_red == SUM_W'(MASS_SCALE))};
    assign w_sum_mag  = sum_mag(r_sum);

    // 8-bit mode: 256*m/255 = m + m/255, sign put back
    assign w_mass_u8 = MASS_FULL_W'(w_sum_mag) + MASS_FULL_W'(w_quo255);
    always_comb begin
        if (r_mode == MODE_S32) begin
            w_mass_full = $signed({r_sum, {FRAC_W{1'b0}}});
        end else if (r_sum[SUM_W-1]) begin
            w_mass_full = $signed(MASS_FULL_W'(-w_mass_u8));
        end else begin
            w_mass_full = $signed(w_mass_u8);
        end
    end

    always_comb begin
        unique case (w_mass_full[MASS_FULL_W-1:MASS_W-1])
            2'b01:   w_mass = $signed({1'b0, {(MASS_W-1){1'b1}}});
            2'b10:   w_mass = $signed({1'b1, {(MASS_W-1){1'b0}}});
            default: w_mass = w_mass_full[MASS_W-1:0];
        endcase
    end

    always_comb begin
        n_state     = r_state;
        o_pop       = 1'b0;
        o_div_req   = '0;
        w_red_step  = 1'b0;
        w_set_mass  = 1'b0;
        w_set_cx    = 1'b0;
        w_set_cy    = 1'b0;
        w_set_empty = 1'b0;
        w_load_out  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop   = 1'b1;
                    n_state = S_MASS;
                end
            end
            S_MASS: begin
                if (!w_red_done) begin
                    w_red_step = 1'b1;
                end else begin
                    w_set_mass = 1'b1;
                    if (w_found) begin
                        o_div_req.start = 1'b1;
                        o_div_req.num   = wsum_num(r_wx);
                        o_div_req.den   = DIV_DEN_W'(r_sum);
                        n_state         = S_CX;
                    end else begin
                        w_set_empty = 1'b1;
                        n_state     = S_OUT;
                    end
                end
            end
            S_CX: begin
                if (i_div_rsp.done) begin
                    w_set_cx        = 1'b1;
                    o_div_req.start = 1'b1;
                    o_div_req.num   = wsum_num(r_wy);
                    o_div_req.den   = DIV_DEN_W'(r_sum);
                    n_state         = S_CY;
                end
            end
            S_CY: begin
                if (i_div_rsp.done) begin
                    w_set_cy = 1'b1;
                    n_state  = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_stall) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_mode  <= i_q_head.mode;
            r_sum   <= i_q_head.sum;
            r_wx    <= i_q_head.wx;
            r_wy    <= i_q_head.wy;
            r_red   <= sum_mag(i_q_head.sum);
            r_red_q <= '0;
        end else if (w_red_step) begin
            r_red   <= n_red;
            r_red_q <= n_red_q;
        end
        if (w_set_mass) begin
            r_mass  <= w_mass;
            r_found <= w_found;
        end
        if (w_set_empty) begin
            r_cx <= COORD_EMPTY;
            r_cy <= COORD_EMPTY;
        end
        if (w_set_cx) begin
            r_cx <= coord_of(i_div_rsp.quo, r_wx[WSUM_W-1]);
        end
        if (w_set_cy) begin
            r_cy <= coord_of(i_div_rsp.quo, r_wy[WSUM_W-1]);
        end
        if (w_load_out) begin
            r_out_mass  <= r_mass;
            r_out_cx    <= r_cx;
            r_out_cy    <= r_cy;
            r_out_found <= r_found;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_mass       = r_out_mass;
    assign o_centroid_x = r_out_cx;
    assign o_centroid_y = r_out_cy;
    assign o_found      = r_out_found;

endmodule

// ===== tb/sv/tb_image_intensity_centroid.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Intensity centroid testbench
// Streams raster frames through the block under many frame sizes and both
// sample modes and checks every mass/centroid result against a predictor.
// ----------------------------------------------------------------------------
module tb_image_intensity_centroid;
    import icen_pkg::*;

    localparam int     IDLE_PCT      = 30;
    localparam int     RANDOM_PIXELS = 850;
    localparam int     SETTLE_CYCLES = 250;     // one back-end pass plus margin
    localparam int     REPORT_MAX    = 10;
    // ~2k pixels, each worst case a full back-end pass plus stalls, taken
    // several times over
    localparam longint CYCLE_LIMIT   = 4_000_000;
    localparam longint COORD_TOP     = (longint'(1) << (COORD_W - 1)) - 1;
    localparam longint MASS_TOP      = (longint'(1) << (MASS_W - 1)) - 1;

    typedef enum int {
        MIX_FULL,
        MIX_BYTE,
        MIX_POSITIVE,
        MIX_EXTREME,
        MIX_SPARSE
    } t_pixel_mix;

    typedef struct packed {
        logic signed [MASS_W-1:0]  mass;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic                      found;
    } t_frame_result;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]       i_cfg_index;
    logic [CFG_W-1:0]           i_cfg_data;
    logic                       i_valid;
    logic                       o_stall;
    logic signed [SAMPLE_W-1:0] i_sample;
    logic                       o_valid;
    logic                       i_stall = 1'b0;
    logic signed [MASS_W-1:0]   o_mass;
    logic signed [COORD_W-1:0]  o_centroid_x;
    logic signed [COORD_W-1:0]  o_centroid_y;
    logic                       o_found;

    // predictor: register copy and running frame sums
    logic [CFG_W-1:0] cfg_width  = CFG_W'(CFG_SIZE_RST);
    logic [CFG_W-1:0] cfg_height = CFG_W'(CFG_SIZE_RST);
    logic             cfg_mode   = MODE_U8;
    int               col_pos    = 0;
    int               row_pos    = 0;
    longint           pix_sum    = 0;
    longint           col_moment = 0;
    longint           row_moment = 0;

    t_frame_result expected_frames[$];
    t_frame_result want;

    int     idle_pct         = IDLE_PCT;
    int     fail_count       = 0;
    int     pixels_sent      = 0;
    int     frames_checked   = 0;
    int     dark_frames      = 0;
    int     clipped_frames   = 0;
    int     settings_applied = 0;
    longint cycle_count      = 0;

    image_intensity_centroid DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_sample     (i_sample),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_mass       (o_mass),
        .o_centroid_x (o_centroid_x),
        .o_centroid_y (o_centroid_y),
        .o_found      (o_found)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     expected_frames.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic int eff_size(logic [CFG_W-1:0] v, int top);
        if (v == 0) return 1;
        if (v > top) return top;
        return v;
    endfunction

    // moment*256/total, truncated toward zero and clipped; total > 0
    function automatic longint clip_centroid(longint moment, longint total);
        logic            neg;
        longint unsigned mag, d, q, r, v;
        neg = (moment < 0);
        mag = neg ? -moment : moment;
        d   = total;
        q   = mag / d;
        r   = mag % d;
        if (q >= (1 << (COORD_W - FRAC_W)))
            v = COORD_TOP + 2;
        else
            v = (q << FRAC_W) + ((r << FRAC_W) / d);
        if (neg) begin
            if (v > COORD_TOP + 1) v = COORD_TOP + 1;
            return -longint'(v);
        end
        if (v > COORD_TOP) v = COORD_TOP;
        return longint'(v);
    endfunction

    function automatic void accumulate_pixel(logic [SAMPLE_W-1:0] value);
        longint        val, scaled;
        int            w, h;
        t_frame_result res;
        w = eff_size(cfg_width, DEF_MAX_WIDTH);
        h = eff_size(cfg_height, DEF_MAX_HEIGHT);
        if (cfg_mode == MODE_U8)
            val = longint'(value[PIX_W-1:0]);
        else
            val = longint'(signed'(value));
        pix_sum    += val;
        col_moment += val * col_pos;
        row_moment += val * row_pos;
        if (col_pos + 1 < w) begin
            col_pos++;
            return;
        end
        col_pos = 0;
        if (row_pos + 1 < h) begin
            row_pos++;
            return;
        end
        // last pixel of the frame
        if (cfg_mode == MODE_U8)
            scaled = (pix_sum * (1 << FRAC_W)) / MASS_SCALE;
        else
            scaled = pix_sum * (1 << FRAC_W);
        if (scaled > MASS_TOP) scaled = MASS_TOP;
        if (scaled < -MASS_TOP - 1) scaled = -MASS_TOP - 1;
        res.mass  = MASS_W'(scaled);
        res.found = (pix_sum > 0);
        if (res.found) begin
            res.cx = COORD_W'(clip_centroid(col_moment, pix_sum));
            res.cy = COORD_W'(clip_centroid(row_moment, pix_sum));
        end else begin
            res.cx = COORD_EMPTY;
            res.cy = COORD_EMPTY;
        end
        expected_frames.push_back(res);
        row_pos    = 0;
        pix_sum    = 0;
        col_moment = 0;
        row_moment = 0;
    endfunction

    // ------------------------------------------------------------------
    // result side: random stall and compare
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1)
            i_stall <= 1'b0;
        else
            i_stall <= ($urandom_range(0, 99) < idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (expected_frames.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("unexpected result: mass=%0d cx=%0d cy=%0d found=%0b",
                             o_mass, o_centroid_x, o_centroid_y, o_found);
            end else begin
                want = expected_frames.pop_front();
                frames_checked++;
                if (!want.found) dark_frames++;
                if (want.found && (want.cx == COORD_W'(COORD_TOP) || want.cy == COORD_W'(COORD_TOP)
                    || want.cx == COORD_W'(-COORD_TOP - 1) || want.cy == COORD_W'(-COORD_TOP - 1)))
                    clipped_frames++;
                if (o_mass !== want.mass || o_centroid_x !== want.cx
                    || o_centroid_y !== want.cy || o_found !== want.found) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("frame %0d mismatch: exp mass=%0d cx=%0d cy=%0d found=%0b, got mass=%0d cx=%0d cy=%0d found=%0b",
                                 frames_checked, want.mass, want.cx, want.cy, want.found,
                                 o_mass, o_centroid_x, o_centroid_y, o_found);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // pixel side
    // ------------------------------------------------------------------
    task automatic send_pixel(input logic [SAMPLE_W-1:0] value);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= value;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        accumulate_pixel(value);
        pixels_sent++;
    endtask

    function automatic logic [SAMPLE_W-1:0] draw_sample(t_pixel_mix mix);
        case (mix)
            MIX_BYTE:     return $urandom_range(0, 255);
            MIX_POSITIVE: return $urandom_range(0, 32'h7FFF_FFFF);
            MIX_EXTREME: begin
                case ($urandom_range(0, 4))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'h0000_0000;
                    3:       return 32'hFFFF_FFFF;
                    default: return 32'h0000_0001;
                endcase
            end
            MIX_SPARSE:   return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
            default:      return $urandom;
        endcase
    endfunction

    task automatic send_frame(input t_pixel_mix mix);
        int n;
        n = eff_size(cfg_width, DEF_MAX_WIDTH) * eff_size(cfg_height, DEF_MAX_HEIGHT);
        repeat (n) send_pixel(draw_sample(mix));
    endtask

    // hold the pixel side until every result is back and the back end is quiet
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (expected_frames.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                                  input logic mode);
        wait_drained();
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_FRAME_WIDTH;
        i_cfg_data  <= w;
        @(posedge i_clk);
        i_cfg_index <= CFG_FRAME_HEIGHT;
        i_cfg_data  <= h;
        @(posedge i_clk);
        i_cfg_index <= CFG_SAMPLE_MODE;
        i_cfg_data  <= CFG_W'(mode);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cfg_width  = w;
        cfg_height = h;
        cfg_mode   = mode;
        settings_applied++;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // zero size registers act as one: every pixel is a frame
    task automatic test_single_pixel_frames();
        apply_settings('0, '0, MODE_U8);
        send_pixel(32'h0000_0000);          // empty frame
        send_pixel(32'h0000_00FF);
        send_pixel(32'hFFFF_FF80);          // upper bits ignored
        apply_settings('0, '0, MODE_S32);
        send_pixel(32'h7FFF_FFFF);
        send_pixel(32'h8000_0000);          // negative mass
        send_pixel(32'h0000_0001);
    endtask

    // tiny positive mass against large moments clips both ways
    task automatic test_centroid_clipping();
        apply_settings(CFG_W'(4), CFG_W'(1), MODE_S32);
        send_pixel(32'h8000_0002);
        send_pixel(32'h0000_0000);
        send_pixel(32'h0000_0000);
        send_pixel(32'h7FFF_FFFF);
        apply_settings(CFG_W'(1), CFG_W'(4), MODE_S32);
        send_pixel(32'h7FFF_FFFF);
        send_pixel(32'h0000_0000);
        send_pixel(32'h0000_0000);
        send_pixel(32'h8000_0002);
    endtask

    task automatic test_ramp_frame();
        apply_settings(CFG_W'(3), CFG_W'(2), MODE_U8);
        send_pixel(32'd10);
        send_pixel(32'd20);
        send_pixel(32'd30);
        send_pixel(32'd40);
        send_pixel(32'd50);
        send_pixel(32'hABCD_EFFF);
    endtask

    // widest row; an oversize width register clamps to the maximum
    task automatic test_largest_frames();
        idle_pct = 0;
        apply_settings('1, '0, MODE_S32);
        send_frame(MIX_EXTREME);
        idle_pct = IDLE_PCT;
    endtask

    function automatic logic [CFG_W-1:0] pick_size();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5) return '0;
        if (roll < 80) return CFG_W'($urandom_range(1, 6));
        return CFG_W'($urandom_range(7, 24));
    endfunction

    task automatic test_random_frames();
        int phase;
        int first_pixel;
        phase       = 0;
        first_pixel = pixels_sent;
        while (pixels_sent - first_pixel < RANDOM_PIXELS) begin
            // a run of phases with neither side idling
            idle_pct = (phase >= 2 && phase < 5) ? 0 : IDLE_PCT;
            apply_settings(pick_size(), pick_size(), $urandom_range(0, 1) != 0);
            repeat ($urandom_range(1, 6)) send_frame(t_pixel_mix'($urandom_range(0, 4)));
            phase++;
        end
        idle_pct = IDLE_PCT;
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_sample    <= '0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_index <= CFG_FRAME_WIDTH;
        i_cfg_data  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_single_pixel_frames();
        test_centroid_clipping();
        test_ramp_frame();
        test_largest_frames();
        test_random_frames();
        wait_drained();

        fail_count += expected_frames.size();
        $display("%0d pixels in %0d frames over %0d size/mode settings checked",
                 pixels_sent, frames_checked, settings_applied);
        $display("%0d frames without positive mass, %0d with a clipped coordinate",
                 dark_frames, clipped_frames);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
